[hw/rtl/fcfs2_pkg.sv]
// shared types and constants of the two-level fcfs scheduler
package fcfs2_pkg;

    localparam int MAX_PER_LEVEL = 16;
    localparam int STORE_DEPTH   = 2 * MAX_PER_LEVEL;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int CNT_W         = $clog2(MAX_PER_LEVEL + 1);

    localparam int HALF_W = 16;
    localparam int TIME_W = 22;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 120;

    typedef struct packed {
        logic [HALF_W-1:0] run;
        logic [HALF_W-1:0] arr;
        logic [HALF_W-1:0] id;
    } rec_t;

    typedef struct packed {
        logic              gt;
        logic [TIME_W-1:0] completion;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
    } alu_res_t;

endpackage

[hw/rtl/fcfs_two_level_schedule.sv]
// top level: batch loader, exchange sort sequencer and fcfs run over two levels
//
// Items load at one per cycle into a 32-entry record store, up to 16 per level
// (system and user). The item with tlast starts the batch: tready drops until
// the final result of the batch is taken. Each level of n records is sorted by
// arrival with a pairwise exchange pass that goes through the single store read
// port and the shared comparator; a level of fewer than two records is not sorted.
// Scheduling then reads one record, computes its times in the shared unit and
// presents the result; the next record is read only once that result is taken.
// Results come system level first, tlast on the final one; a batch of no records
// gives no result. tuser flags overflow on every result of a batch in which
// records were dropped.
module fcfs_two_level_schedule
    import fcfs2_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // proc_id, arrival, burst
    input  logic [1:0]            s_tuser,   // has_process, level
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // proc_id, arrival, burst, completion,
                                             // turnaround, waiting, zero pad
    output logic [1:0]            m_tuser,   // out_level, overflow
    output logic                  m_tlast
);

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_SINIT = 4'd1;
    localparam logic [3:0] ST_RDA   = 4'd2;
    localparam logic [3:0] ST_LDA   = 4'd3;
    localparam logic [3:0] ST_RDB   = 4'd4;
    localparam logic [3:0] ST_CMP   = 4'd5;
    localparam logic [3:0] ST_WRA   = 4'd6;
    localparam logic [3:0] ST_RSEL  = 4'd7;
    localparam logic [3:0] ST_CALC  = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    localparam logic [CNT_W-1:0]  LEVEL_CAP = CNT_W'(MAX_PER_LEVEL);
    localparam logic [ADDR_W-1:0] USER_BASE = ADDR_W'(MAX_PER_LEVEL);

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  scnt_reg, scnt_next;
    logic [CNT_W-1:0]  ucnt_reg, ucnt_next;
    logic              ovf_reg, ovf_next;
    logic              lvl_reg, lvl_next;
    logic [CNT_W-1:0]  a_reg, a_next;
    logic [CNT_W-1:0]  b_reg, b_next;
    logic [TIME_W-1:0] time_reg, time_next;
    rec_t              hold_reg, hold_next;

    logic              m_tvalid_reg, m_tvalid_next;
    rec_t              out_rec_reg, out_rec_next;
    logic [TIME_W-1:0] out_comp_reg, out_comp_next;
    logic [TIME_W-1:0] out_tat_reg, out_tat_next;
    logic [TIME_W-1:0] out_wt_reg, out_wt_next;
    logic              out_lvl_reg, out_lvl_next;
    logic              out_ovf_reg, out_ovf_next;
    logic              out_last_reg, out_last_next;

    logic              we;
    logic [ADDR_W-1:0] waddr;
    rec_t              wdata;
    logic [ADDR_W-1:0] raddr;
    rec_t              rdata;
    alu_res_t          alu_res;

    logic [CNT_W-1:0]  cur_cnt;
    logic [ADDR_W-1:0] base;
    logic [CNT_W-1:0]  a_inc;
    rec_t              in_rec;
    logic              in_has;
    logic              in_lvl;
    logic              in_fire;

    assign cur_cnt = lvl_reg ? ucnt_reg : scnt_reg;
    assign base    = lvl_reg ? USER_BASE : '0;
    assign a_inc   = a_reg + 1'b1;

    assign in_rec.id  = s_tdata[15:0];
    assign in_rec.arr = s_tdata[31:16];
    assign in_rec.run = s_tdata[47:32];
    assign in_has     = s_tuser[0];
    assign in_lvl     = s_tuser[1];

    assign s_tready = (state_reg == ST_LOAD);
    assign in_fire  = s_tvalid && s_tready;

    fcfs2_store u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    fcfs2_alu u_alu (
        .sort_mode (state_reg == ST_CMP),
        .hold_arr  (hold_reg.arr),
        .cur_time  (time_reg),
        .rec       (rdata),
        .res       (alu_res)
    );

    always_comb
    begin
        state_next    = state_reg;
        scnt_next     = scnt_reg;
        ucnt_next     = ucnt_reg;
        ovf_next      = ovf_reg;
        lvl_next      = lvl_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        time_next     = time_reg;
        hold_next     = hold_reg;
        m_tvalid_next = m_tvalid_reg;
        out_rec_next  = out_rec_reg;
        out_comp_next = out_comp_reg;
        out_tat_next  = out_tat_reg;
        out_wt_next   = out_wt_reg;
        out_lvl_next  = out_lvl_reg;
        out_ovf_next  = out_ovf_reg;
        out_last_next = out_last_reg;
        we            = 1'b0;
        waddr         = base + ADDR_W'(b_reg);
        wdata         = hold_reg;
        raddr         = base + ADDR_W'(a_reg);

        unique case (state_reg)
            ST_LOAD:
            begin
                wdata = in_rec;
                if (in_fire)
                begin
                    if (in_has)
                    begin
                        if (!in_lvl)
                        begin
                            waddr = ADDR_W'(scnt_reg);
                            if (scnt_reg < LEVEL_CAP)
                            begin
                                we        = 1'b1;
                                scnt_next = scnt_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                        else
                        begin
                            waddr = USER_BASE + ADDR_W'(ucnt_reg);
                            if (ucnt_reg < LEVEL_CAP)
                            begin
                                we        = 1'b1;
                                ucnt_next = ucnt_reg + 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                        end
                    end
                    if (s_tlast)
                    begin
                        lvl_next   = 1'b0;
                        state_next = ST_SINIT;
                    end
                end
            end

            ST_SINIT:
            begin
                a_next = '0;
                if (cur_cnt > CNT_W'(1))
                begin
                    state_next = ST_RDA;
                end
                else if (!lvl_reg)
                begin
                    lvl_next = 1'b1;
                end
                else
                begin
                    lvl_next   = 1'b0;
                    time_next  = '0;
                    a_next     = '0;
                    state_next = ST_RSEL;
                end
            end

            ST_RDA:
            begin
                raddr      = base + ADDR_W'(a_reg);
                state_next = ST_LDA;
            end

            ST_LDA:
            begin
                hold_next  = rdata;
                b_next     = a_inc;
                state_next = ST_RDB;
            end

            ST_RDB:
            begin
                raddr      = base + ADDR_W'(b_reg);
                state_next = ST_CMP;
            end

            ST_CMP:
            begin
                // held entry later than entry b: they trade places
                if (alu_res.gt)
                begin
                    we        = 1'b1;
                    waddr     = base + ADDR_W'(b_reg);
                    wdata     = hold_reg;
                    hold_next = rdata;
                end
                if (b_reg == cur_cnt - 1'b1)
                begin
                    state_next = ST_WRA;
                end
                else
                begin
                    b_next     = b_reg + 1'b1;
                    state_next = ST_RDB;
                end
            end

            ST_WRA:
            begin
                we     = 1'b1;
                waddr  = base + ADDR_W'(a_reg);
                wdata  = hold_reg;
                a_next = a_inc;
                if (a_inc + 1'b1 < cur_cnt)
                begin
                    state_next = ST_RDA;
                end
                else
                begin
                    state_next = ST_SINIT;
                    if (!lvl_reg)
                    begin
                        lvl_next = 1'b1;
                    end
                    else
                    begin
                        lvl_next   = 1'b0;
                        time_next  = '0;
                        a_next     = '0;
                        state_next = ST_RSEL;
                    end
                end
            end

            ST_RSEL:
            begin
                raddr = base + ADDR_W'(a_reg);
                if (a_reg < cur_cnt)
                begin
                    state_next = ST_CALC;
                end
                else if (!lvl_reg)
                begin
                    lvl_next = 1'b1;
                    a_next   = '0;
                end
                else
                begin
                    // batch done, stores clear
                    lvl_next   = 1'b0;
                    a_next     = '0;
                    scnt_next  = '0;
                    ucnt_next  = '0;
                    ovf_next   = 1'b0;
                    time_next  = '0;
                    state_next = ST_LOAD;
                end
            end

            ST_CALC:
            begin
                time_next     = alu_res.completion;
                out_rec_next  = rdata;
                out_comp_next = alu_res.completion;
                out_tat_next  = alu_res.turnaround;
                out_wt_next   = alu_res.waiting;
                out_lvl_next  = lvl_reg;
                out_ovf_next  = ovf_reg;
                out_last_next = (a_inc == cur_cnt) && (lvl_reg || (ucnt_reg == '0));
                m_tvalid_next = 1'b1;
                state_next    = ST_OUT;
            end

            ST_OUT:
            begin
                if (m_tready)
                begin
                    m_tvalid_next = 1'b0;
                    a_next        = a_inc;
                    state_next    = ST_RSEL;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            scnt_reg     <= '0;
            ucnt_reg     <= '0;
            ovf_reg      <= 1'b0;
            lvl_reg      <= 1'b0;
            a_reg        <= '0;
            b_reg        <= '0;
            time_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scnt_reg     <= scnt_next;
            ucnt_reg     <= ucnt_next;
            ovf_reg      <= ovf_next;
            lvl_reg      <= lvl_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            time_reg     <= time_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        out_rec_reg  <= out_rec_next;
        out_comp_reg <= out_comp_next;
        out_tat_reg  <= out_tat_next;
        out_wt_reg   <= out_wt_next;
        out_lvl_reg  <= out_lvl_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, out_wt_reg, out_tat_reg, out_comp_reg,
                       out_rec_reg.run, out_rec_reg.arr, out_rec_reg.id};
    assign m_tuser  = {out_ovf_reg, out_lvl_reg};
    assign m_tlast  = out_last_reg;

endmodule

[hw/rtl/fcfs2_store.sv]
// process record store, one write port and one registered read port
module fcfs2_store
    import fcfs2_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  rec_t              wdata,
    input  logic [ADDR_W-1:0] raddr,
    output rec_t              rdata
);

    rec_t mem [STORE_DEPTH];
    rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/fcfs2_alu.sv]
// shared compare and time unit: arrival compare for the sort, fcfs timing for the run
module fcfs2_alu
    import fcfs2_pkg::*;
(
    input  logic              sort_mode,
    input  logic [HALF_W-1:0] hold_arr,
    input  logic [TIME_W-1:0] cur_time,
    input  rec_t              rec,
    output alu_res_t          res
);

    logic [TIME_W-1:0] lhs;
    logic [TIME_W-1:0] rhs;
    logic              gt;
    logic [TIME_W-1:0] arr_ext;
    logic [TIME_W-1:0] start;

    assign arr_ext = TIME_W'(rec.arr);

    // one comparator serves both phases
    assign lhs = sort_mode ? TIME_W'(hold_arr) : arr_ext;
    assign rhs = sort_mode ? arr_ext : cur_time;
    assign gt  = lhs > rhs;

    assign start = gt ? arr_ext : cur_time;

    always_comb
    begin
        res.gt         = gt;
        res.completion = start + TIME_W'(rec.run);
        res.turnaround = res.completion - arr_ext;
        res.waiting    = start - arr_ext;
    end

endmodule

[test/tb_fcfs_two_level_schedule.sv]
// testbench for the two-level fcfs batch scheduler: directed and random batches
`timescale 1ns / 100ps

module tb_fcfs_two_level_schedule;
    import fcfs2_pkg::*;

    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_TAIL     = 700;
    localparam int RANDOM_ITEMS   = 410;

    typedef enum bit {LVL_SYSTEM = 1'b0, LVL_USER = 1'b1} level_t;

    typedef struct {
        bit                has_proc;
        level_t            lvl;
        logic [HALF_W-1:0] id;
        logic [HALF_W-1:0] arr;
        logic [HALF_W-1:0] burst;
        bit                last;
    } sched_item_t;

    typedef struct {
        level_t            lvl;
        logic [HALF_W-1:0] id;
        logic [HALF_W-1:0] arr;
        logic [HALF_W-1:0] burst;
        logic [TIME_W-1:0] completion;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        bit                ovf;
        bit                last;
    } sched_res_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // proc_id, arrival, burst
    logic [1:0]            s_tuser = '0;   // has_process, level
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // proc_id, arrival, burst, completion,
                                           // turnaround, waiting, zero pad
    logic [1:0]            m_tuser;        // out_level, overflow
    logic                  m_tlast;

    // predictor state
    rec_t       lvl_store [2][MAX_PER_LEVEL];
    int         lvl_cnt [2];
    bit         dropped_seen;
    sched_res_t sched_results_due [$];

    int mismatch_count = 0;
    int useful_items = 0;
    bit src_steady = 1'b0;
    bit sink_steady = 1'b0;
    bit hold_req = 1'b0;

    fcfs_two_level_schedule dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic int pick_gap(bit long_ok);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92 || !long_ok)
            return $urandom_range(1, 3);
        return $urandom_range(10, 50);
    endfunction

    // pairwise exchange over one level, not stable for equal arrivals
    function automatic void sort_level(int lv);
        rec_t t;
        for (int a = 0; a + 1 < lvl_cnt[lv]; a++)
            for (int b = a + 1; b < lvl_cnt[lv]; b++)
                if (lvl_store[lv][a].arr > lvl_store[lv][b].arr)
                begin
                    t = lvl_store[lv][a];
                    lvl_store[lv][a] = lvl_store[lv][b];
                    lvl_store[lv][b] = t;
                end
    endfunction

    function automatic void schedule_accept(sched_item_t it);
        int unsigned now;
        int unsigned fin;
        int total;
        int emitted;
        sched_res_t r;
        if (it.has_proc)
        begin
            if (lvl_cnt[it.lvl] < MAX_PER_LEVEL)
            begin
                lvl_store[it.lvl][lvl_cnt[it.lvl]] = '{run: it.burst, arr: it.arr, id: it.id};
                lvl_cnt[it.lvl]++;
            end
            else
                dropped_seen = 1'b1;
        end
        if (it.last)
        begin
            now = 0;
            emitted = 0;
            total = lvl_cnt[0] + lvl_cnt[1];
            for (int lv = 0; lv < 2; lv++)
            begin
                sort_level(lv);
                for (int a = 0; a < lvl_cnt[lv]; a++)
                begin
                    if (now < lvl_store[lv][a].arr)
                        now = 32'(lvl_store[lv][a].arr);
                    fin = now + lvl_store[lv][a].run;
                    r.lvl        = level_t'(lv);
                    r.id         = lvl_store[lv][a].id;
                    r.arr        = lvl_store[lv][a].arr;
                    r.burst      = lvl_store[lv][a].run;
                    r.completion = TIME_W'(fin);
                    r.turnaround = TIME_W'(fin - lvl_store[lv][a].arr);
                    r.waiting    = TIME_W'(fin - lvl_store[lv][a].arr - lvl_store[lv][a].run);
                    r.ovf        = dropped_seen;
                    emitted++;
                    r.last       = (emitted == total);
                    now = fin;
                    sched_results_due.push_back(r);
                end
            end
            lvl_cnt[0] = 0;
            lvl_cnt[1] = 0;
            dropped_seen = 1'b0;
        end
    endfunction

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    function automatic sched_item_t make_item(bit has_proc, level_t lvl, int unsigned id,
                                              int unsigned arr, int unsigned burst, bit last);
        sched_item_t it;
        it.has_proc = has_proc;
        it.lvl      = lvl;
        it.id       = HALF_W'(id);
        it.arr      = HALF_W'(arr);
        it.burst    = HALF_W'(burst);
        it.last     = last;
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(sched_item_t it);
        int gap;
        gap = src_steady ? 0 : pick_gap(1'b1);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {it.burst, it.arr, it.id};
        s_tuser  <= {it.lvl, it.has_proc};
        s_tlast  <= it.last;
        do
            @(posedge clk);
        while (!s_tready);
        schedule_accept(it);
        if (it.has_proc || it.last)
            useful_items++;
        @(negedge clk);
    endtask

    task automatic sender_stop();
        s_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        sender_stop();
        while (sched_results_due.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_bare_markers();
        send_item(make_item(1'b0, LVL_USER, $urandom, $urandom, $urandom, 1'b0));
        // last with both stores empty gives nothing
        send_item(make_item(1'b0, LVL_SYSTEM, $urandom, $urandom, $urandom, 1'b1));
        wait_drained();
    endtask

    task automatic test_extremes();
        send_item(make_item(1'b1, LVL_SYSTEM, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
        send_item(make_item(1'b1, LVL_SYSTEM, 16'h0000, 16'h0000, 16'h0000, 1'b0));
        // equal arrivals reorder under the exchange sort
        send_item(make_item(1'b1, LVL_SYSTEM, 16'h1111, 5, 3, 1'b0));
        send_item(make_item(1'b1, LVL_SYSTEM, 16'h2222, 5, 7, 1'b0));
        send_item(make_item(1'b1, LVL_SYSTEM, 16'h3333, 1, 2, 1'b0));
        send_item(make_item(1'b1, LVL_USER, 16'hAAAA, 16'h0000, 16'hFFFF, 1'b0));
        // record carried on the last item
        send_item(make_item(1'b1, LVL_USER, 16'h5555, 16'h0000, 1, 1'b1));
        wait_drained();
    endtask

    task automatic test_overflow();
        // the seventeenth record is dropped on the last item itself
        for (int i = 0; i <= MAX_PER_LEVEL; i++)
            send_item(make_item(1'b1, LVL_SYSTEM, $urandom, $urandom_range(0, 40),
                                $urandom_range(0, 20), i == MAX_PER_LEVEL));
        wait_drained();
    endtask

    task automatic random_batch(int n_recs);
        int lvl_mode;
        int arr_hi;
        int burst_hi;
        bit last_on_rec;
        level_t lv;
        lvl_mode = $urandom_range(0, 5);
        arr_hi   = ($urandom_range(0, 2) == 0) ? 65535 : ($urandom_range(0, 1) ? 255 : 15);
        burst_hi = ($urandom_range(0, 2) == 0) ? 65535 : ($urandom_range(0, 1) ? 255 : 15);
        last_on_rec = (n_recs > 0) && $urandom_range(0, 1);
        for (int i = 0; i < n_recs; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_item(make_item(1'b0, level_t'($urandom_range(0, 1)), $urandom,
                                    $urandom, $urandom, 1'b0));
            if (lvl_mode == 0)
                lv = LVL_SYSTEM;
            else if (lvl_mode == 1)
                lv = LVL_USER;
            else
                lv = level_t'($urandom_range(0, 1));
            send_item(make_item(1'b1, lv, $urandom, $urandom_range(0, arr_hi),
                                $urandom_range(0, burst_hi), last_on_rec && i == n_recs - 1));
        end
        if (!last_on_rec)
            send_item(make_item(1'b0, level_t'($urandom_range(0, 1)), $urandom,
                                $urandom, $urandom, 1'b1));
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        random_batch(24);
        random_batch(6);
        wait_drained();
    endtask

    task automatic test_random_batches();
        int kind;
        while (useful_items < RANDOM_ITEMS)
        begin
            src_steady  = ($urandom_range(0, 4) == 0);
            sink_steady = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 7)
                random_batch($urandom_range(0, 10));
            else if (kind < 9)
                random_batch($urandom_range(11, 24));
            else
                random_batch($urandom_range(30, 38));
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            // long hold starts once the first result of the batch is waiting
            if (hold_req && m_tvalid)
            begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!sink_steady)
                    stall_left = pick_gap(1'b1);
            end
        end
    end

    initial
    begin : result_check
        sched_res_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (sched_results_due.size() == 0)
                begin
                    $error("unexpected result: proc_id expected none, got 0x%0h",
                           m_tdata[15:0]);
                    mismatch_count++;
                end
                else
                begin
                    want = sched_results_due.pop_front();
                    check_field("out_level", 32'(want.lvl), 32'(m_tuser[0]));
                    check_field("out_proc_id", 32'(want.id), 32'(m_tdata[15:0]));
                    check_field("out_arrival", 32'(want.arr), 32'(m_tdata[31:16]));
                    check_field("out_burst", 32'(want.burst), 32'(m_tdata[47:32]));
                    check_field("completion", 32'(want.completion), 32'(m_tdata[69:48]));
                    check_field("turnaround", 32'(want.turnaround), 32'(m_tdata[91:70]));
                    check_field("waiting", 32'(want.waiting), 32'(m_tdata[113:92]));
                    check_field("overflow", 32'(want.ovf), 32'(m_tuser[1]));
                    check_field("out_last", 32'(want.last), 32'(m_tlast));
                end
            end
        end
    end

    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle = 0;
            else
                idle++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        lvl_cnt[0] = 0;
        lvl_cnt[1] = 0;
        dropped_seen = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_bare_markers();
        test_extremes();
        test_overflow();
        test_backpressure();
        test_random_batches();

        wait_drained();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[fcfs_two_level_schedule.f]
hw/rtl/fcfs2_pkg.sv
hw/rtl/fcfs2_store.sv
hw/rtl/fcfs2_alu.sv
hw/rtl/fcfs_two_level_schedule.sv
test/tb_fcfs_two_level_schedule.sv
